FILE: rtl/fcpwm_pkg.sv
// ----------------------------------------------------------------------------
// fcpwm_pkg
// Shared types and constants of the four-channel PWM timer: register indexes,
// operation codes, field widths and the fixed-point reciprocal of one hundred.
// ----------------------------------------------------------------------------
package fcpwm_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CHANNEL_WIDTH   = 2;
    localparam int DUTY_WIDTH      = 8;
    localparam int PERCENT_WIDTH   = 7;
    localparam int VALUE_WIDTH     = 16;
    localparam int LANES           = 4;

    // duty * period / 100 is done as duty * (period * ceil(2^30 / 100)) >> 30.
    // The rounding error stays below 0.005, under the 0.01 step of the quotient.
    localparam int RECIP_SHIFT  = 30;
    localparam int RECIP_WIDTH  = 24;
    localparam int SCALED_WIDTH = VALUE_WIDTH + RECIP_WIDTH;
    localparam int PRODUCT_WIDTH = SCALED_WIDTH + PERCENT_WIDTH;
    localparam logic [RECIP_WIDTH-1:0] RECIP_MULT = 24'd10737419;

    localparam logic [PERCENT_WIDTH-1:0] FULL_PERCENT = 7'd100;
    localparam logic [VALUE_WIDTH-1:0]   PERIOD_RESET = 16'hFFFF;
    localparam logic [SCALED_WIDTH-1:0]  PERIOD_SCALED_RESET =
        SCALED_WIDTH'(64'(PERIOD_RESET) * 64'(RECIP_MULT));

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PRESCALER      = 2'd0,
        REG_PERIOD         = 2'd1,
        REG_CHANNEL_ENABLE = 2'd2,
        REG_COUNTER_ENABLE = 2'd3
    } reg_index_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_DUTY = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]  prescaler;
        logic [VALUE_WIDTH-1:0]  period;
        logic [SCALED_WIDTH-1:0] period_scaled;
        logic [LANES-1:0]        channel_enable;
        logic                    counter_enable;
    } cfg_t;

    typedef struct packed {
        logic [LANES-1:0]       pwm_out;
        logic [VALUE_WIDTH-1:0] count_value;
        logic                   update_event;
    } tmr_result_t;

endpackage

FILE: rtl/fcpwm_cfg.sv
// ----------------------------------------------------------------------------
// fcpwm_cfg
// Configuration register file. Also keeps period times the reciprocal of one
// hundred, so the duty conversion needs a single multiply per item.
// ----------------------------------------------------------------------------
module fcpwm_cfg (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [fcpwm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [fcpwm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output fcpwm_pkg::cfg_t                       cfg
);

    fcpwm_pkg::cfg_t                          cfg_reg;
    fcpwm_pkg::cfg_t                          cfg_next;
    logic [fcpwm_pkg::SCALED_WIDTH-1:0]       scaled;

    assign scaled = fcpwm_pkg::SCALED_WIDTH'(cfg_data) *
                    fcpwm_pkg::SCALED_WIDTH'(fcpwm_pkg::RECIP_MULT);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (fcpwm_pkg::reg_index_t'(cfg_index))
                fcpwm_pkg::REG_PRESCALER:
                begin
                    cfg_next.prescaler = cfg_data;
                end
                fcpwm_pkg::REG_PERIOD:
                begin
                    cfg_next.period        = cfg_data;
                    cfg_next.period_scaled = scaled;
                end
                fcpwm_pkg::REG_CHANNEL_ENABLE:
                begin
                    cfg_next.channel_enable = cfg_data[fcpwm_pkg::LANES-1:0];
                end
                fcpwm_pkg::REG_COUNTER_ENABLE:
                begin
                    cfg_next.counter_enable = cfg_data[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescaler      <= '0;
            cfg_reg.period         <= fcpwm_pkg::PERIOD_RESET;
            cfg_reg.period_scaled  <= fcpwm_pkg::PERIOD_SCALED_RESET;
            cfg_reg.channel_enable <= '0;
            cfg_reg.counter_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/fcpwm_duty.sv
// ----------------------------------------------------------------------------
// fcpwm_duty
// Duty to compare conversion: saturate at 100 percent, then
// duty * period / 100 truncated, by one multiply against the scaled period.
// ----------------------------------------------------------------------------
module fcpwm_duty (
    input  logic [fcpwm_pkg::DUTY_WIDTH-1:0]   duty_percent,
    input  logic [fcpwm_pkg::SCALED_WIDTH-1:0] period_scaled,
    output logic [fcpwm_pkg::VALUE_WIDTH-1:0]  compare
);

    logic [fcpwm_pkg::PERCENT_WIDTH-1:0] duty_sat;
    logic [fcpwm_pkg::PRODUCT_WIDTH-1:0] product;

    assign duty_sat = (duty_percent > fcpwm_pkg::DUTY_WIDTH'(fcpwm_pkg::FULL_PERCENT))
                    ? fcpwm_pkg::FULL_PERCENT
                    : duty_percent[fcpwm_pkg::PERCENT_WIDTH-1:0];

    assign product = fcpwm_pkg::PRODUCT_WIDTH'(duty_sat) *
                     fcpwm_pkg::PRODUCT_WIDTH'(period_scaled);

    // quotient never exceeds the period, so the 16 bits from bit 30 up hold it all
    assign compare = product[fcpwm_pkg::RECIP_SHIFT +: fcpwm_pkg::VALUE_WIDTH];

endmodule

FILE: rtl/fcpwm_counter.sv
// ----------------------------------------------------------------------------
// fcpwm_counter
// Timer state: prescaler, main up-counter, preload and active compares.
// Computes the state after one transaction and the channel levels from it.
// ----------------------------------------------------------------------------
module fcpwm_counter #(
    parameter int CHANNELS      = 4,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  fcpwm_pkg::opcode_t                  opcode,
    input  logic [fcpwm_pkg::CHANNEL_WIDTH-1:0] channel,
    input  logic [fcpwm_pkg::VALUE_WIDTH-1:0]   compare,
    input  fcpwm_pkg::cfg_t                     cfg,
    output fcpwm_pkg::tmr_result_t              result
);

    localparam int CMP_WIDTH = (COUNTER_WIDTH > fcpwm_pkg::VALUE_WIDTH)
                             ? COUNTER_WIDTH : fcpwm_pkg::VALUE_WIDTH;

    logic [fcpwm_pkg::VALUE_WIDTH-1:0] presc_reg;
    logic [fcpwm_pkg::VALUE_WIDTH-1:0] presc_next;
    logic [COUNTER_WIDTH-1:0]          main_reg;
    logic [COUNTER_WIDTH-1:0]          main_next;
    logic [fcpwm_pkg::VALUE_WIDTH-1:0] pending_reg [CHANNELS];
    logic [fcpwm_pkg::VALUE_WIDTH-1:0] pending_next [CHANNELS];
    logic [fcpwm_pkg::VALUE_WIDTH-1:0] active_reg [CHANNELS];
    logic [fcpwm_pkg::VALUE_WIDTH-1:0] active_next [CHANNELS];
    logic                              run;
    logic                              presc_carry;
    logic                              wrap;
    logic                              reload;
    logic [fcpwm_pkg::LANES-1:0]       levels;

    assign run         = (opcode == fcpwm_pkg::OP_TICK) && cfg.counter_enable;
    assign presc_carry = presc_reg >= cfg.prescaler;
    assign wrap        = CMP_WIDTH'(main_reg) >= CMP_WIDTH'(cfg.period);
    assign reload      = run && presc_carry && wrap;

    always_comb
    begin
        presc_next = presc_reg;
        main_next  = main_reg;
        if (run)
        begin
            if (presc_carry)
            begin
                presc_next = '0;
                main_next  = wrap ? '0 : main_reg + 1'b1;
            end
            else
            begin
                presc_next = presc_reg + 1'b1;
            end
        end
    end

    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        assign pending_next[i] = ((opcode == fcpwm_pkg::OP_DUTY) &&
                                  (channel == fcpwm_pkg::CHANNEL_WIDTH'(i)))
                               ? compare : pending_reg[i];
        assign active_next[i]  = reload ? pending_reg[i] : active_reg[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                pending_reg[i] <= '0;
                active_reg[i]  <= '0;
            end
            else if (step)
            begin
                pending_reg[i] <= pending_next[i];
                active_reg[i]  <= active_next[i];
            end
        end
    end

    for (genvar i = 0; i < fcpwm_pkg::LANES; i++)
    begin : g_level
        if (i < CHANNELS)
        begin : g_used
            assign levels[i] = cfg.channel_enable[i] &&
                               (CMP_WIDTH'(main_next) < CMP_WIDTH'(active_next[i]));
        end
        else
        begin : g_unused
            assign levels[i] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presc_reg <= '0;
            main_reg  <= '0;
        end
        else if (step)
        begin
            presc_reg <= presc_next;
            main_reg  <= main_next;
        end
    end

    assign result.pwm_out      = levels;
    assign result.count_value  = fcpwm_pkg::VALUE_WIDTH'(main_next);
    assign result.update_event = reload;

endmodule

FILE: rtl/four_channel_pwm_timer_core.sv
// ----------------------------------------------------------------------------
// four_channel_pwm_timer_core
// Four-channel edge-aligned PWM timer, up-counting, active-high outputs.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready) carries one transaction per timer
//   tick (opcode tick) or per duty update (opcode duty, channel, duty_percent).
//   Result channel (result_valid/result_ready) returns exactly one transaction
//   per item: channel levels, counter value, update event and the compare
//   computed by a duty update (zero on a tick).
//   Configuration is a plain write port (cfg_write_en, cfg_index, cfg_data),
//   written only while no transaction is in flight (user's rule, unenforced).
// Path: an accepted item waits in the input register, then one pass of counter
//   and duty logic carries it into the result register, whose valid flag drives
//   result_valid.
// Throughput: one transaction per cycle while the result side is not stalled;
//   the duty conversion is one multiply against the preloaded scaled period.
// Reset: counters, compares and configuration registers take their reset
//   values, both channels come up empty; the period reads 65535.
// Stall: while result_ready is low the result register holds and the input
//   register keeps one more item; item_ready drops only when both are full.
// ----------------------------------------------------------------------------
module four_channel_pwm_timer_core #(
    parameter int CHANNELS      = 4,
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_write_en,
    input  logic [fcpwm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [fcpwm_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    // item channel
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  opcode,
    input  logic [fcpwm_pkg::CHANNEL_WIDTH-1:0]   channel,
    input  logic [fcpwm_pkg::DUTY_WIDTH-1:0]      duty_percent,
    // result channel
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [fcpwm_pkg::LANES-1:0]           pwm_out,
    output logic [fcpwm_pkg::VALUE_WIDTH-1:0]     count_value,
    output logic                                  update_event,
    output logic [fcpwm_pkg::VALUE_WIDTH-1:0]     compare_value
);

    fcpwm_pkg::cfg_t                       cfg;
    fcpwm_pkg::tmr_result_t                tmr_result;

    // input register
    logic                                  in_vld_reg;
    logic                                  in_vld_next;
    fcpwm_pkg::opcode_t                    op_reg;
    logic [fcpwm_pkg::CHANNEL_WIDTH-1:0]   chan_reg;
    logic [fcpwm_pkg::DUTY_WIDTH-1:0]      duty_reg;

    // result register
    logic                                  out_vld_reg;
    logic                                  out_vld_next;
    fcpwm_pkg::tmr_result_t                res_reg;
    logic [fcpwm_pkg::VALUE_WIDTH-1:0]     cmp_reg;

    logic                                  advance;
    logic                                  item_take;
    logic [fcpwm_pkg::VALUE_WIDTH-1:0]     duty_compare;

    // The held item moves on whenever the result register is free or drains.
    assign advance    = in_vld_reg && (!out_vld_reg || result_ready);
    assign item_ready = !in_vld_reg || advance;
    assign item_take  = item_valid && item_ready;

    assign in_vld_next  = item_ready ? item_valid : in_vld_reg;
    assign out_vld_next = (!out_vld_reg || result_ready) ? in_vld_reg : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            op_reg   <= fcpwm_pkg::opcode_t'(opcode);
            chan_reg <= channel;
            duty_reg <= duty_percent;
        end
    end

    fcpwm_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    fcpwm_duty u_duty (
        .duty_percent  (duty_reg),
        .period_scaled (cfg.period_scaled),
        .compare       (duty_compare)
    );

    // Timer state commits only on the cycle the item enters the result register.
    fcpwm_counter #(
        .CHANNELS      (CHANNELS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_counter (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .opcode  (op_reg),
        .channel (chan_reg),
        .compare (duty_compare),
        .cfg     (cfg),
        .result  (tmr_result)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= tmr_result;
            cmp_reg <= (op_reg == fcpwm_pkg::OP_DUTY) ? duty_compare : '0;
        end
    end

    assign result_valid  = out_vld_reg;
    assign pwm_out       = res_reg.pwm_out;
    assign count_value   = res_reg.count_value;
    assign update_event  = res_reg.update_event;
    assign compare_value = cmp_reg;

`ifndef SYNTHESIS
    // back-pressure only when both registers hold a transaction
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (in_vld_reg && out_vld_reg && !result_ready))
        else $error("item_ready low with room in the pipeline");

    // a wrap always restarts the counter at zero
    a_update_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.update_event) |-> (res_reg.count_value == '0))
        else $error("update event with nonzero count");

    // a tick never reports a compare; an update only comes from a tick
    a_update_is_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_reg.update_event) |-> (cmp_reg == '0))
        else $error("update event together with a duty compare");

    // the result register empties only through an accepted transaction
    a_result_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_vld_reg) |-> $past(result_ready))
        else $error("result dropped without being taken");
`endif

endmodule

FILE: tb/sv/pwm_timer_checker.sv
// ----------------------------------------------------------------------------
// pwm_timer_checker
// Watches the configuration port and both channels of the PWM timer core,
// predicts every result transaction from its own copy of the timer state and
// compares the results field by field, in order.
// ----------------------------------------------------------------------------
module pwm_timer_checker
    import fcpwm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       item_valid,
    input  logic                       item_ready,
    input  logic                       opcode,
    input  logic [CHANNEL_WIDTH-1:0]   channel,
    input  logic [DUTY_WIDTH-1:0]      duty_percent,
    input  logic                       result_valid,
    input  logic                       result_ready,
    input  logic [LANES-1:0]           pwm_out,
    input  logic [VALUE_WIDTH-1:0]     count_value,
    input  logic                       update_event,
    input  logic [VALUE_WIDTH-1:0]     compare_value,
    output int                         error_count,
    output int                         outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LANES-1:0]       pwm;
        logic [VALUE_WIDTH-1:0] count;
        logic                   upd;
        logic [VALUE_WIDTH-1:0] compare;
    } timer_view_t;

    // shadow registers
    logic [VALUE_WIDTH-1:0] cfg_prescaler;
    logic [VALUE_WIDTH-1:0] cfg_period;
    logic [LANES-1:0]       cfg_chan_en;
    logic                   cfg_count_en;

    // shadow timer state
    logic [VALUE_WIDTH-1:0] presc_cnt;
    logic [VALUE_WIDTH-1:0] main_cnt;
    logic [VALUE_WIDTH-1:0] preload_cmp [LANES];
    logic [VALUE_WIDTH-1:0] active_cmp  [LANES];

    timer_view_t expected_q [$];
    timer_view_t want;

    // Applies one item to the shadow state, returns the predicted levels, count, update and compare.
    function automatic timer_view_t step_timer(input opcode_t op,
                                               input logic [CHANNEL_WIDTH-1:0] ch,
                                               input logic [DUTY_WIDTH-1:0] duty);
        timer_view_t view;
        int unsigned pct;
        int unsigned cmp;
        int          i;
        view = '0;
        if (op == OP_DUTY) begin
            pct = (duty > FULL_PERCENT) ? FULL_PERCENT : duty;
            cmp = (pct * cfg_period) / FULL_PERCENT;
            view.compare = VALUE_WIDTH'(cmp);
            preload_cmp[ch] = VALUE_WIDTH'(cmp);
        end
        else if (cfg_count_en) begin
            if (presc_cnt >= cfg_prescaler) begin
                presc_cnt = '0;
                if (main_cnt >= cfg_period) begin
                    main_cnt = '0;
                    view.upd = 1'b1;
                    for (i = 0; i < LANES; i++)
                        active_cmp[i] = preload_cmp[i];
                end
                else begin
                    main_cnt = main_cnt + 1'b1;
                end
            end
            else begin
                presc_cnt = presc_cnt + 1'b1;
            end
        end
        for (i = 0; i < LANES; i++)
            view.pwm[i] = cfg_chan_en[i] && (main_cnt < active_cmp[i]);
        view.count = main_cnt;
        return view;
    endfunction

    task automatic check_field(input string name, input logic [VALUE_WIDTH-1:0] exp_v,
                               input logic [VALUE_WIDTH-1:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_prescaler = '0;
            cfg_period    = PERIOD_RESET;
            cfg_chan_en   = '0;
            cfg_count_en  = 1'b0;
            presc_cnt     = '0;
            main_cnt      = '0;
            for (int i = 0; i < LANES; i++) begin
                preload_cmp[i] = '0;
                active_cmp[i]  = '0;
            end
            expected_q.delete();
        end
        else begin
            if (cfg_write_en) begin
                case (reg_index_t'(cfg_index))
                    REG_PRESCALER:      cfg_prescaler = cfg_data;
                    REG_PERIOD:         cfg_period    = cfg_data;
                    REG_CHANNEL_ENABLE: cfg_chan_en   = cfg_data[LANES-1:0];
                    REG_COUNTER_ENABLE: cfg_count_en  = cfg_data[0];
                    default: ;
                endcase
            end
            // results leave before the item of this edge is queued
            if (result_valid && result_ready) begin
                if (expected_q.size() == 0) begin
                    error_count++;
                    $display("%0t ns: result transaction with none expected, actual %h",
                             $time, {pwm_out, count_value, update_event, compare_value});
                end
                else begin
                    want = expected_q.pop_front();
                    check_field("pwm_out", VALUE_WIDTH'(want.pwm), VALUE_WIDTH'(pwm_out));
                    check_field("count_value", want.count, count_value);
                    check_field("update_event", VALUE_WIDTH'(want.upd),
                                VALUE_WIDTH'(update_event));
                    check_field("compare_value", want.compare, compare_value);
                end
            end
            if (item_valid && item_ready)
                expected_q.push_back(step_timer(opcode_t'(opcode), channel, duty_percent));
        end
        outstanding = expected_q.size();
    end

endmodule

FILE: tb/sv/tb_four_channel_pwm_timer_core.sv
// ----------------------------------------------------------------------------
// tb_four_channel_pwm_timer_core
// Drives ticks and duty updates into the PWM timer core under a series of
// register settings, with random idling on both channels, a long result
// hold-off and a full drain, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_four_channel_pwm_timer_core;
    import fcpwm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 3;
    localparam int HOLD_CYCLES   = 40;      // long result back-pressure stretch
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 75;
    localparam int IDLE_PCT      = 32;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 10;      // settle time before the verdict
    localparam int RUN_LIMIT_NS  = 2_000_000;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_write_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index    = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data     = '0;
    logic                       item_valid   = 1'b0;
    logic                       item_ready;
    logic                       opcode       = 1'b0;
    logic [CHANNEL_WIDTH-1:0]   channel      = '0;
    logic [DUTY_WIDTH-1:0]      duty_percent = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic [LANES-1:0]           pwm_out;
    logic [VALUE_WIDTH-1:0]     count_value;
    logic                       update_event;
    logic [VALUE_WIDTH-1:0]     compare_value;

    int error_count;
    int outstanding;

    // Knobs that steer the sender and the receiver process.
    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;
    bit hold_req  = 1'b0;   // set once by the sender
    bit hold_done = 1'b0;   // set once by the receiver

    four_channel_pwm_timer_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .channel      (channel),
        .duty_percent (duty_percent),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pwm_out      (pwm_out),
        .count_value  (count_value),
        .update_event (update_event),
        .compare_value(compare_value)
    );

    pwm_timer_checker timer_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .channel      (channel),
        .duty_percent (duty_percent),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .pwm_out      (pwm_out),
        .count_value  (count_value),
        .update_event (update_event),
        .compare_value(compare_value),
        .error_count  (error_count),
        .outstanding  (outstanding)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #RUN_LIMIT_NS;
        $display("tb_four_channel_pwm_timer_core: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: ready changes only at falling edges. When the sender asks
    // for it, ready is held low for HOLD_CYCLES so the core fills both of its
    // registers and drops item_ready while items keep being offered.
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                result_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            result_ready = !(recv_gaps && ($urandom_range(99) < IDLE_PCT));
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers. All of them start and end on a falling edge.
    // ------------------------------------------------------------------------

    // Offer one item transaction and wait until the core takes it. Idle
    // cycles, if any, come before valid goes up; once up, valid and the
    // payload hold until the accepting rising edge.
    task automatic send_item(input opcode_t op, input logic [CHANNEL_WIDTH-1:0] ch,
                             input logic [DUTY_WIDTH-1:0] duty);
        while (send_gaps && ($urandom_range(99) < IDLE_PCT))
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid   = 1'b1;
        opcode       = op;
        channel      = ch;
        duty_percent = duty;
        do
            @(posedge clk);
        while (!item_ready);
        @(negedge clk);
    endtask

    // Ticks carry random channel and duty; the core must ignore them.
    task automatic send_tick();
        send_item(OP_TICK, CHANNEL_WIDTH'($urandom), DUTY_WIDTH'($urandom));
    endtask

    // Stop offering and wait for every outstanding result transaction.
    // Every item yields exactly one result, so the core is idle afterwards.
    task automatic drain_results();
        item_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] value);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = value;
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    // Register setting for one random phase: mostly short periods and small
    // prescalers so the counter wraps often, with the extremes forced on a
    // few phases. The main counter is never cleared between phases, so a smaller
    // period than the current count shows up naturally.
    task automatic set_phase_regs(input int phase);
        logic [VALUE_WIDTH-1:0] presc;
        logic [VALUE_WIDTH-1:0] per;
        int                     pick;
        pick  = $urandom_range(99);
        presc = (pick < 50) ? '0 :
                (pick < 88) ? VALUE_WIDTH'($urandom_range(1, 3)) :
                              VALUE_WIDTH'($urandom_range(4, 65535));
        pick  = $urandom_range(99);
        per   = (pick < 75) ? VALUE_WIDTH'($urandom_range(0, 12)) :
                              VALUE_WIDTH'($urandom_range(0, 65535));
        if (phase == 10)
            presc = 16'hFFFF;           // counter effectively frozen
        if (phase == 11)
            per = '0;                   // wrap on every counter advance
        if (phase == 12)
        begin
            presc = '0;
            per   = 16'hFFFF;
        end
        write_reg(REG_PRESCALER, presc);
        write_reg(REG_PERIOD, per);
        write_reg(REG_CHANNEL_ENABLE, (phase == 0) ? 16'hF : 16'($urandom_range(0, 15)));
        write_reg(REG_COUNTER_ENABLE, ($urandom_range(99) < 88) ? 16'd1 : 16'd0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        int n;
        int guard;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reset settings, counting still disabled. The tick must
        // leave everything as it is; duties above hundred saturate to period.
        send_tick();
        send_item(OP_DUTY, 2'd0, 8'd0);
        send_item(OP_DUTY, 2'd1, 8'd100);
        send_item(OP_DUTY, 2'd2, 8'd255);
        send_item(OP_DUTY, 2'd3, 8'd101);
        send_item(OP_DUTY, 2'd1, 8'd1);
        send_item(OP_DUTY, 2'd2, 8'd99);

        // Directed: short period, counter through a full wrap. Duty updates
        // only touch the preload compares; the outputs follow at the wrap.
        drain_results();
        write_reg(REG_PERIOD, 16'd4);
        write_reg(REG_PRESCALER, 16'd0);
        write_reg(REG_CHANNEL_ENABLE, 16'hB);
        write_reg(REG_COUNTER_ENABLE, 16'd1);
        send_item(OP_DUTY, 2'd0, 8'd25);
        send_item(OP_DUTY, 2'd1, 8'd50);
        send_item(OP_DUTY, 2'd2, 8'd75);
        send_item(OP_DUTY, 2'd3, 8'd100);
        repeat (6) send_tick();

        // Directed: prescaler dropped below the running prescale count.
        drain_results();
        write_reg(REG_PRESCALER, 16'd3);
        repeat (2) send_tick();
        drain_results();
        write_reg(REG_PRESCALER, 16'd0);
        send_tick();

        // Directed: period dropped below the running count forces a wrap.
        drain_results();
        write_reg(REG_PERIOD, 16'hFFFF);
        repeat (3) send_tick();
        drain_results();
        write_reg(REG_PERIOD, 16'd1);
        send_tick();

        // Random phases. Phase 3 holds off the result side while the sender
        // offers back to back; phases 6 and 7 run without idling on either
        // side; phase 9 pauses the sender halfway until all results are in.
        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            set_phase_regs(phase);
            send_gaps = !(phase == 3 || phase == 6 || phase == 7);
            recv_gaps = !(phase == 6 || phase == 7);
            if (phase == 3)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 9 && n == PHASE_ITEMS / 2)
                    drain_results();
                if ($urandom_range(99) < 70)
                    send_tick();
                else
                    send_item(OP_DUTY, CHANNEL_WIDTH'($urandom_range(0, 3)),
                              ($urandom_range(99) < 70) ? DUTY_WIDTH'($urandom_range(0, 100))
                                                        : DUTY_WIDTH'($urandom_range(0, 255)));
            end
        end

        // Wind down: wait for the last results, then give stray results a
        // chance to show up before the verdict.
        item_valid = 1'b0;
        recv_gaps  = 1'b0;
        for (guard = 0; guard < DRAIN_LIMIT && outstanding != 0; guard++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0 && outstanding == 0)
        begin
            $display("tb_four_channel_pwm_timer_core: done, clean");
        end
        else
        begin
            if (outstanding != 0)
                $display("%0t ns: %0d result transactions never arrived", $time, outstanding);
            $display("tb_four_channel_pwm_timer_core: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/fcpwm_pkg.sv
rtl/fcpwm_cfg.sv
rtl/fcpwm_duty.sv
rtl/fcpwm_counter.sv
rtl/four_channel_pwm_timer_core.sv
tb/sv/pwm_timer_checker.sv
tb/sv/tb_four_channel_pwm_timer_core.sv
